// ===== design/led_matrix_serial_frame_sender_defines.svh =====
// ----------------------------------------------------------------------------
// LED matrix serial frame sender: assertion macros
// Shared property forms for the sender's checks.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SERIAL_FRAME_SENDER_DEFINES_SVH
`define LED_MATRIX_SERIAL_FRAME_SENDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LMSFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LMSFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lmsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix serial frame sender package
// Request/result types, operation codes and command frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmsfs_pkg;

    localparam int MATRIX_COUNT_DEF = 4;
    localparam int COLS_PER_MATRIX  = 8;
    localparam int WORD_W           = 12;

    // operation codes
    localparam logic [2:0] OP_WRITE_COLUMN = 3'd0;
    localparam logic [2:0] OP_SEND_SCREEN  = 3'd1;
    localparam logic [2:0] OP_RAW_COMMAND  = 3'd2;
    localparam logic [2:0] OP_SETUP        = 3'd3;
    localparam logic [2:0] OP_BRIGHTNESS   = 3'd4;

    // command frames
    localparam logic [WORD_W-1:0] CMD_SYS_ON      = 12'b1000_0000_0010;
    localparam logic [WORD_W-1:0] CMD_LED_ON      = 12'b1000_0000_0110;
    localparam logic [WORD_W-1:0] CMD_CLOCK_RC    = 12'b1000_0011_0000;
    localparam logic [WORD_W-1:0] CMD_LAYOUT      = 12'b1000_0100_0000;
    localparam logic [WORD_W-1:0] CMD_BRIGHT_BASE = 12'b1001_0100_0000;
    localparam logic [WORD_W-1:0] CMD_BLINK_OFF   = 12'b1000_0001_0000;
    localparam logic [WORD_W-1:0] WRITE_PREAMBLE  = 12'b0010_1000_0000;
    localparam logic [3:0]        SETUP_BRIGHT    = 4'd8;

    localparam logic [3:0] BITS_COMMAND  = 4'd12;
    localparam logic [3:0] BITS_PREAMBLE = 4'd10;
    localparam logic [3:0] BITS_ROW      = 4'd8;

    localparam logic [2:0] SETUP_LAST = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  column_index;
        logic [7:0]  column_bits;
        logic [11:0] command_word;
        logic [3:0]  brightness_level;
    } request_t;

    typedef struct packed {
        logic [11:0] serial_word;
        logic [3:0]  bit_count;
        logic        frame_end;
        logic        last;
    } result_t;

    function automatic logic [WORD_W-1:0] bright_frame(input logic [3:0] level);
        return CMD_BRIGHT_BASE + {7'd0, level, 1'b0};
    endfunction

    function automatic logic [WORD_W-1:0] setup_frame(input logic [2:0] idx);
        logic [WORD_W-1:0] w;
        unique case (idx)
            3'd0:    w = CMD_SYS_ON;
            3'd1:    w = CMD_LED_ON;
            3'd2:    w = CMD_CLOCK_RC;
            3'd3:    w = CMD_LAYOUT;
            3'd4:    w = bright_frame(SETUP_BRIGHT);
            default: w = CMD_BLINK_OFF;
        endcase
        return w;
    endfunction

endpackage

// ===== design/lmsfs_fbuf.sv =====
// ----------------------------------------------------------------------------
// LED matrix framebuffer
// One byte per column, one write and one registered read port; unwritten
// columns read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmsfs_fbuf #(
    parameter int MATRIX_COUNT = lmsfs_pkg::MATRIX_COUNT_DEF
) (
    clk,
    rst_n,
    wr_en,
    wr_addr,
    wr_data,
    rd_en,
    rd_addr,
    rd_data
);
    localparam int COLUMN_TOTAL = MATRIX_COUNT * lmsfs_pkg::COLS_PER_MATRIX;
    localparam int ADDR_W       = $clog2(COLUMN_TOTAL);

    input  logic              clk;
    input  logic              rst_n;
    input  logic              wr_en;
    input  logic [ADDR_W-1:0] wr_addr;
    input  logic [7:0]        wr_data;
    input  logic              rd_en;
    input  logic [ADDR_W-1:0] rd_addr;
    output logic [7:0]        rd_data;

    logic [7:0]              fb_mem [COLUMN_TOTAL];
    logic [COLUMN_TOTAL-1:0] valid_reg;
    logic [7:0]              rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fb_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? fb_mem[rd_addr] : 8'd0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/led_matrix_serial_frame_sender.sv =====
// ----------------------------------------------------------------------------
// LED matrix serial frame sender
// Column framebuffer plus sequencer that frames serial words for a matrix
// controller: screen dumps, raw commands, setup and brightness.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low.
//   Write column stores a byte and gives no result.
//   Raw command and brightness give one word, in the cycle after the request;
//   busy never rises for them.
//   Setup gives six words, one per cycle; busy falls as the last one is shown.
//   Send screen gives the preamble in the cycle after the request, then the
//   row bytes in a steady run of one per cycle. The framebuffer is read
//   one column per cycle through its single read port, eight columns per
//   matrix, and the transposed rows of one matrix go out while the next
//   matrix loads, so that read port sets the pace.
//   Each word appears on result for exactly one cycle with result_valid;
//   the receiver cannot stall, so nothing is held back.
//   Reset clears the framebuffer to zero (valid bits) and idles the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_matrix_serial_frame_sender_defines.svh"

module led_matrix_serial_frame_sender #(
    parameter int MATRIX_COUNT = lmsfs_pkg::MATRIX_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lmsfs_pkg::request_t request,
    output logic                result_valid,
    output lmsfs_pkg::result_t  result
);
    localparam int COLUMN_TOTAL = MATRIX_COUNT * lmsfs_pkg::COLS_PER_MATRIX;
    localparam int ADDR_W       = $clog2(COLUMN_TOTAL);
    localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(COLUMN_TOTAL - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCREEN
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         setup_idx_reg, setup_idx_next;

    // column read pipeline
    logic               rd_active_reg, rd_active_next;
    logic [ADDR_W-1:0]  rd_col_reg, rd_col_next;
    logic               rd_pend_reg;      // read data valid this cycle
    logic               rd_tail_reg;      // ... and it is a matrix's last column
    logic               rd_final_reg;     // ... of the last matrix

    // transpose buffers: stage collects columns, hold feeds row bytes
    logic [7:0]         stage_reg [8];
    logic [7:0]         stage_next [8];
    logic [7:0]         hold_reg [8];
    logic               hold_final_reg, hold_final_next;
    logic               emit_active_reg, emit_active_next;
    logic [2:0]         row_reg, row_next;

    logic               out_valid_reg, out_valid_next;
    lmsfs_pkg::result_t out_reg, out_next;

    logic               accept;
    logic               fb_wr_en;
    logic [7:0]         rd_data;
    logic [7:0]         row_byte;
    logic               load_hold;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign fb_wr_en = accept && (request.operation == lmsfs_pkg::OP_WRITE_COLUMN)
                      && (32'(request.column_index) < COLUMN_TOTAL);

    lmsfs_fbuf #(
        .MATRIX_COUNT(MATRIX_COUNT)
    ) u_fbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fb_wr_en),
        .wr_addr(ADDR_W'(request.column_index)),
        .wr_data(request.column_bits),
        .rd_en  (rd_active_reg),
        .rd_addr(rd_col_reg),
        .rd_data(rd_data)
    );

    // stage shifts in one column per returned read; column 0 ends up at index 0
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            stage_next[i] = rd_pend_reg ? stage_reg[i+1] : stage_reg[i];
        end
        stage_next[7] = rd_pend_reg ? rd_data : stage_reg[7];
    end

    assign load_hold = rd_pend_reg && rd_tail_reg;

    // row byte: bit 'row' of each column, first column in the MSB
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            row_byte[7-c] = hold_reg[c][row_reg];
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        setup_idx_next   = setup_idx_reg;
        rd_active_next   = rd_active_reg;
        rd_col_next      = rd_col_reg;
        hold_final_next  = hold_final_reg;
        emit_active_next = emit_active_reg;
        row_next         = row_reg;
        out_valid_next   = 1'b0;
        out_next         = out_reg;

        if (rd_active_reg)
        begin
            rd_col_next = rd_col_reg + ADDR_W'(1);
            if (rd_col_reg == LAST_COL)
            begin
                rd_active_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.operation)
                        lmsfs_pkg::OP_SEND_SCREEN:
                        begin
                            state_next     = ST_SCREEN;
                            rd_active_next = 1'b1;
                            rd_col_next    = '0;
                            out_valid_next = 1'b1;
                            out_next       = '{serial_word: lmsfs_pkg::WRITE_PREAMBLE,
                                               bit_count:   lmsfs_pkg::BITS_PREAMBLE,
                                               frame_end:   1'b0,
                                               last:        1'b0};
                        end
                        lmsfs_pkg::OP_RAW_COMMAND:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{serial_word: request.command_word,
                                               bit_count:   lmsfs_pkg::BITS_COMMAND,
                                               frame_end:   1'b1,
                                               last:        1'b1};
                        end
                        lmsfs_pkg::OP_SETUP:
                        begin
                            state_next     = ST_SETUP;
                            setup_idx_next = 3'd1;
                            out_valid_next = 1'b1;
                            out_next       = '{serial_word: lmsfs_pkg::setup_frame(3'd0),
                                               bit_count:   lmsfs_pkg::BITS_COMMAND,
                                               frame_end:   1'b1,
                                               last:        1'b0};
                        end
                        lmsfs_pkg::OP_BRIGHTNESS:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{serial_word: lmsfs_pkg::bright_frame(
                                                   request.brightness_level),
                                               bit_count:   lmsfs_pkg::BITS_COMMAND,
                                               frame_end:   1'b1,
                                               last:        1'b1};
                        end
                        default:
                        begin
                            // write column is handled by the framebuffer;
                            // unused codes do nothing
                        end
                    endcase
                end
            end

            ST_SETUP:
            begin
                out_valid_next = 1'b1;
                out_next       = '{serial_word: lmsfs_pkg::setup_frame(setup_idx_reg),
                                   bit_count:   lmsfs_pkg::BITS_COMMAND,
                                   frame_end:   1'b1,
                                   last:        (setup_idx_reg == lmsfs_pkg::SETUP_LAST)};
                setup_idx_next = setup_idx_reg + 3'd1;
                if (setup_idx_reg == lmsfs_pkg::SETUP_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCREEN:
            begin
                if (emit_active_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{serial_word: {4'd0, row_byte},
                                       bit_count:   lmsfs_pkg::BITS_ROW,
                                       frame_end:   hold_final_reg && (row_reg == 3'd7),
                                       last:        hold_final_reg && (row_reg == 3'd7)};
                    row_next       = row_reg + 3'd1;
                    if (row_reg == 3'd7)
                    begin
                        emit_active_next = 1'b0;
                        if (hold_final_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                // a fresh matrix lands exactly as the previous one finishes
                if (load_hold)
                begin
                    emit_active_next = 1'b1;
                    row_next         = 3'd0;
                    hold_final_next  = rd_final_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            setup_idx_reg   <= 3'd0;
            rd_active_reg   <= 1'b0;
            rd_col_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            rd_tail_reg     <= 1'b0;
            rd_final_reg    <= 1'b0;
            hold_final_reg  <= 1'b0;
            emit_active_reg <= 1'b0;
            row_reg         <= 3'd0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            setup_idx_reg   <= setup_idx_next;
            rd_active_reg   <= rd_active_next;
            rd_col_reg      <= rd_col_next;
            rd_pend_reg     <= rd_active_reg;
            rd_tail_reg     <= (rd_col_reg[2:0] == 3'd7);
            rd_final_reg    <= (rd_col_reg == LAST_COL);
            hold_final_reg  <= hold_final_next;
            emit_active_reg <= emit_active_next;
            row_reg         <= row_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    // transpose buffers, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            stage_reg[i] <= stage_next[i];
            if (load_hold)
            begin
                hold_reg[i] <= stage_next[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `LMSFS_ASSERT_NOW(a_last_ends_frame, result_valid && result.last,
        result.frame_end, "last word does not end its frame")
    `LMSFS_ASSERT_NOW(a_idle_word_is_last, result_valid && !busy,
        result.last, "word shown while idle is not the last of its request")
    `LMSFS_ASSERT_NEXT(a_screen_goes_busy,
        start && !busy && (request.operation == lmsfs_pkg::OP_SEND_SCREEN),
        busy, "send screen did not raise busy")

endmodule

// ===== tb/sv/tb_led_matrix_serial_frame_sender.sv =====
// ----------------------------------------------------------------------------
// LED matrix serial frame sender testbench
// Drives requests for every operation through the start/busy handshake.
// Keeps its own shadow framebuffer and predicts each serial word, then
// compares every strobed result, field by field, in order. Request idle
// rate changes from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_matrix_serial_frame_sender;

    localparam int COLUMN_TOTAL = lmsfs_pkg::MATRIX_COUNT_DEF * lmsfs_pkg::COLS_PER_MATRIX;
    // Even with long idle gaps between requests, the run stays far below this.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 64;

    // operation codes the block ignores
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    lmsfs_pkg::request_t request;
    logic                result_valid;
    lmsfs_pkg::result_t  result;

    logic [7:0]         shadow_columns [COLUMN_TOTAL];
    lmsfs_pkg::result_t pending_words [$];
    lmsfs_pkg::result_t want_word;
    int                 idle_pct;
    int                 error_count;
    int                 cycle_count;

    led_matrix_serial_frame_sender #(
        .MATRIX_COUNT (lmsfs_pkg::MATRIX_COUNT_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // One row of one matrix: column 0 of the matrix lands in the MSB.
    function automatic logic [7:0] matrix_row_byte(input int mtx, input int row);
        logic [7:0] q;
        int         idx;
        q = '0;
        for (int col = 0; col < lmsfs_pkg::COLS_PER_MATRIX; col++)
        begin
            idx = mtx * lmsfs_pkg::COLS_PER_MATRIX + col;
            q   = {q[6:0], (idx < COLUMN_TOTAL) ? shadow_columns[idx][row] : 1'b0};
        end
        return q;
    endfunction

    function automatic lmsfs_pkg::result_t serial_frame(input logic [11:0] word,
                                                        input logic [3:0] nbits,
                                                        input logic fe);
        lmsfs_pkg::result_t r;
        r.serial_word = word;
        r.bit_count   = nbits;
        r.frame_end   = fe;
        r.last        = 1'b0;
        return r;
    endfunction

    // Update the shadow framebuffer and queue the words one request causes.
    function automatic void predict_frames(input lmsfs_pkg::request_t req);
        lmsfs_pkg::result_t words [$];
        case (req.operation)
            lmsfs_pkg::OP_WRITE_COLUMN:
            begin
                if (int'(req.column_index) < COLUMN_TOTAL)
                    shadow_columns[req.column_index] = req.column_bits;
            end
            lmsfs_pkg::OP_SEND_SCREEN:
            begin
                words.push_back(serial_frame(lmsfs_pkg::WRITE_PREAMBLE,
                    lmsfs_pkg::BITS_PREAMBLE, 1'b0));
                for (int mtx = 0; mtx < lmsfs_pkg::MATRIX_COUNT_DEF; mtx++)
                    for (int row = 0; row < 8; row++)
                        words.push_back(serial_frame({4'd0, matrix_row_byte(mtx, row)},
                            lmsfs_pkg::BITS_ROW,
                            (mtx == lmsfs_pkg::MATRIX_COUNT_DEF - 1) && (row == 7)));
            end
            lmsfs_pkg::OP_RAW_COMMAND:
                words.push_back(serial_frame(req.command_word,
                    lmsfs_pkg::BITS_COMMAND, 1'b1));
            lmsfs_pkg::OP_SETUP:
            begin
                words.push_back(serial_frame(lmsfs_pkg::CMD_SYS_ON,
                    lmsfs_pkg::BITS_COMMAND, 1'b1));
                words.push_back(serial_frame(lmsfs_pkg::CMD_LED_ON,
                    lmsfs_pkg::BITS_COMMAND, 1'b1));
                words.push_back(serial_frame(lmsfs_pkg::CMD_CLOCK_RC,
                    lmsfs_pkg::BITS_COMMAND, 1'b1));
                words.push_back(serial_frame(lmsfs_pkg::CMD_LAYOUT,
                    lmsfs_pkg::BITS_COMMAND, 1'b1));
                words.push_back(serial_frame(lmsfs_pkg::CMD_BRIGHT_BASE
                    + (12'(lmsfs_pkg::SETUP_BRIGHT) << 1), lmsfs_pkg::BITS_COMMAND, 1'b1));
                words.push_back(serial_frame(lmsfs_pkg::CMD_BLINK_OFF,
                    lmsfs_pkg::BITS_COMMAND, 1'b1));
            end
            lmsfs_pkg::OP_BRIGHTNESS:
                words.push_back(serial_frame(lmsfs_pkg::CMD_BRIGHT_BASE
                    + (12'(req.brightness_level) << 1), lmsfs_pkg::BITS_COMMAND, 1'b1));
            default: ;
        endcase
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            pending_words.push_back(words[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    function automatic lmsfs_pkg::request_t random_request(input logic [2:0] op);
        lmsfs_pkg::request_t r;
        r.operation        = op;
        r.column_index     = 5'($urandom);
        r.column_bits      = 8'($urandom);
        r.command_word     = 12'($urandom);
        r.brightness_level = 4'($urandom);
        return r;
    endfunction

    // Start stays high after acceptance; the next call either keeps it high or
    // drops it for an idle gap, so it is never written twice in one step.
    task automatic send_request(input lmsfs_pkg::request_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_frames(req);
    endtask

    task automatic send_op(input logic [2:0] op);
        send_request(random_request(op));
    endtask

    // ------------------------------------------------------------------------
    // Result checker: results cannot be held off, so sample every strobe.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result: serial_word %h bit_count %0d",
                       result.serial_word, result.bit_count);
                error_count++;
            end
            else
            begin
                want_word = pending_words.pop_front();
                if (result.serial_word !== want_word.serial_word)
                begin
                    $error("serial_word expected %h, got %h",
                           want_word.serial_word, result.serial_word);
                    error_count++;
                end
                if (result.bit_count !== want_word.bit_count)
                begin
                    $error("bit_count expected %0d, got %0d",
                           want_word.bit_count, result.bit_count);
                    error_count++;
                end
                if (result.frame_end !== want_word.frame_end)
                begin
                    $error("frame_end expected %b, got %b",
                           want_word.frame_end, result.frame_end);
                    error_count++;
                end
                if (result.last !== want_word.last)
                begin
                    $error("last expected %b, got %b", want_word.last, result.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("led_matrix_serial_frame_sender test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Command extremes, brightness extremes, setup and the ignored codes.
    task automatic test_commands();
        lmsfs_pkg::request_t r;
        idle_pct = 0;
        r = random_request(lmsfs_pkg::OP_RAW_COMMAND);
        r.command_word = 12'h000;
        send_request(r);
        r.command_word = 12'hFFF;
        send_request(r);
        r.command_word = 12'hA5A;
        send_request(r);
        r = random_request(lmsfs_pkg::OP_BRIGHTNESS);
        r.brightness_level = 4'd0;
        send_request(r);
        r.brightness_level = 4'd15;
        send_request(r);
        r.brightness_level = 4'd8;
        send_request(r);
        send_op(lmsfs_pkg::OP_SETUP);
        send_op(OP_SPARE_LO);
        send_op(OP_SPARE_MID);
        send_op(OP_SPARE_HI);
        send_op(lmsfs_pkg::OP_RAW_COMMAND);
    endtask

    // Cleared screen, then edge columns and matrix boundaries.
    task automatic test_screen();
        lmsfs_pkg::request_t r;
        idle_pct = 0;
        send_op(lmsfs_pkg::OP_SEND_SCREEN);
        r = random_request(lmsfs_pkg::OP_WRITE_COLUMN);
        r.column_index = 5'd0;
        r.column_bits  = 8'hFF;
        send_request(r);
        r.column_index = 5'(COLUMN_TOTAL - 1);
        r.column_bits  = 8'h80;
        send_request(r);
        r.column_index = 5'd7;
        r.column_bits  = 8'h01;
        send_request(r);
        r.column_index = 5'd8;
        r.column_bits  = 8'h5A;
        send_request(r);
        r.column_index = 5'd16;
        r.column_bits  = 8'h00;
        send_request(r);
        send_op(lmsfs_pkg::OP_SEND_SCREEN);
        send_op(lmsfs_pkg::OP_BRIGHTNESS);
    endtask

    // Column writes are the most common request, so screen dumps carry varied content.
    task automatic test_random(input int count, input int pct);
        int sent;
        int pick;
        idle_pct = pct;
        sent     = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            sent++;
            if (pick < 42)
                send_op(lmsfs_pkg::OP_WRITE_COLUMN);
            else if (pick < 54)
                send_op(lmsfs_pkg::OP_SEND_SCREEN);
            else if (pick < 68)
                send_op(lmsfs_pkg::OP_RAW_COMMAND);
            else if (pick < 77)
                send_op(lmsfs_pkg::OP_SETUP);
            else if (pick < 93)
                send_op(lmsfs_pkg::OP_BRIGHTNESS);
            else
            begin
                send_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
                sent--;
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        request     <= '0;
        idle_pct    = 0;
        error_count = 0;
        cycle_count = 0;
        foreach (shadow_columns[i])
            shadow_columns[i] = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_commands();
        test_screen();
        test_random(105, 0);
        test_random(100, 79);
        test_random(100, 37);

        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("led_matrix_serial_frame_sender test passed");
        else
            $display("led_matrix_serial_frame_sender test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lmsfs_pkg.sv
design/lmsfs_fbuf.sv
design/led_matrix_serial_frame_sender.sv
tb/sv/tb_led_matrix_serial_frame_sender.sv
